// File: rtl/core/abeh_pkg.sv
// ----------------------------------------------------------------------------
// abeh_pkg
// Shared types, codes and lookup functions of the aligned base error histogram.
// ----------------------------------------------------------------------------
package abeh_pkg;

    localparam int NUM_QUALITIES_DEF = 40;
    localparam int MAX_CYCLES_DEF    = 256;

    // Wide enough for the store with the default parameters.
    localparam int JOB_ADDR_W = 21;

    localparam logic [11:0] SKIP_FLAGS      = 12'd2816;
    localparam logic [11:0] FIRST_MATE_FLAG = 12'h040;
    localparam logic [7:0]  CHAR_N          = 8'h4E;
    localparam logic [3:0]  NT_N            = 4'd15;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_CIGAR = 2'd1,
        KIND_BASE  = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_IGNORED  = 3'd1,
        ST_BAD_QUAL = 3'd2,
        ST_BAD_BASE = 3'd3,
        ST_BAD_CYC  = 3'd4,
        ST_NO_MATCH = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        CIG_M  = 4'd0,
        CIG_I  = 4'd1,
        CIG_D  = 4'd2,
        CIG_N  = 4'd3,
        CIG_S  = 4'd4,
        CIG_H  = 4'd5,
        CIG_EQ = 4'd7,
        CIG_X  = 4'd8
    } t_cigar;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef struct packed {
        t_status                 status;
        t_op                     op;
        logic                    mism;
        logic [JOB_ADDR_W-1:0]   addr;
        logic [27:0]             read_cycle;
        logic [31:0]             ref_offset;
        logic [31:0]             records_read;
        logic [31:0]             records_skipped;
    } t_job;

    // Bit 2 set marks a code that is not a single base.
    function automatic logic [2:0] base_index(input logic [3:0] code);
        logic [2:0] r;
        case (code)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd1;
            4'd4:    r = 3'd2;
            4'd8:    r = 3'd3;
            default: r = 3'd4;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] nt_code(input logic [7:0] ch);
        logic [7:0] u;
        logic [3:0] r;
        u = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'd32 : ch;
        case (u)
            8'h3D:   r = 4'd0;
            8'h41:   r = 4'd1;
            8'h43:   r = 4'd2;
            8'h4D:   r = 4'd3;
            8'h47:   r = 4'd4;
            8'h52:   r = 4'd5;
            8'h53:   r = 4'd6;
            8'h56:   r = 4'd7;
            8'h54:   r = 4'd8;
            8'h55:   r = 4'd8;
            8'h57:   r = 4'd9;
            8'h59:   r = 4'd10;
            8'h48:   r = 4'd11;
            8'h4B:   r = 4'd12;
            8'h44:   r = 4'd13;
            8'h42:   r = 4'd14;
            default: r = 4'd15;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/abeh_queue.sv
// ----------------------------------------------------------------------------
// abeh_queue
// Two-entry queue of classified jobs between the front and the back part.
// ----------------------------------------------------------------------------
module abeh_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  abeh_pkg::t_job   i_job,
    input  logic             i_pop,
    output abeh_pkg::t_job   o_job,
    output logic             o_empty,
    output logic             o_full
);
    abeh_pkg::t_job r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);
endmodule

// File: rtl/core/abeh_front.sv
// ----------------------------------------------------------------------------
// abeh_front
// Accepts items, tracks record positions and counters, and classifies each
// item into a job for the histogram store.
// ----------------------------------------------------------------------------
module abeh_front #(
    parameter int NUM_QUALITIES = abeh_pkg::NUM_QUALITIES_DEF,
    parameter int MAX_CYCLES    = abeh_pkg::MAX_CYCLES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [1:0]       i_kind,
    input  logic [11:0]      i_flags,
    input  logic             i_contig_negative,
    input  logic [3:0]       i_cigar_code,
    input  logic [27:0]      i_op_length,
    input  logic [3:0]       i_read_base,
    input  logic [7:0]       i_ref_char,
    input  logic [7:0]       i_quality,
    input  logic             i_sel_mate,
    input  logic [1:0]       i_sel_base,
    input  logic [5:0]       i_sel_quality,
    input  logic [7:0]       i_sel_cycle,
    output abeh_pkg::t_job   o_job
);
    logic [27:0] r_read_cycle, n_read_cycle;
    logic [31:0] r_ref_offset, n_ref_offset;
    logic [27:0] r_match_rem,  n_match_rem;
    logic        r_mate2,      n_mate2;
    logic        r_skipped,    n_skipped;
    logic [31:0] r_rec_read,   n_rec_read;
    logic [31:0] r_rec_skip,   n_rec_skip;

    logic [27:0] cyc_add;
    logic [27:0] ref_add;
    logic [29:0] cyc_sum;
    logic [33:0] ref_sum;
    logic [2:0]  bidx;
    logic        idx_mate;
    logic [1:0]  idx_base;
    logic [7:0]  idx_qual;
    logic [27:0] idx_cyc;
    logic [31:0] idx_full;
    abeh_pkg::t_status status;
    abeh_pkg::t_op     op;

    always_comb begin
        cyc_add = '0;
        ref_add = '0;
        case (abeh_pkg::t_cigar'(i_cigar_code))
            abeh_pkg::CIG_EQ, abeh_pkg::CIG_X: begin
                cyc_add = i_op_length;
                ref_add = i_op_length;
            end
            abeh_pkg::CIG_I, abeh_pkg::CIG_S, abeh_pkg::CIG_H: cyc_add = i_op_length;
            abeh_pkg::CIG_D, abeh_pkg::CIG_N: ref_add = i_op_length;
            default: ;
        endcase
    end

    // Flushing a cut-short match and the new op fold into one saturating sum.
    assign cyc_sum = {2'b00, r_read_cycle} + {2'b00, r_match_rem} + {2'b00, cyc_add};
    assign ref_sum = {2'b00, r_ref_offset} + {6'd0, r_match_rem} + {6'd0, ref_add};
    assign bidx    = abeh_pkg::base_index(i_read_base);

    always_comb begin
        n_read_cycle = r_read_cycle;
        n_ref_offset = r_ref_offset;
        n_match_rem  = r_match_rem;
        n_mate2      = r_mate2;
        n_skipped    = r_skipped;
        n_rec_read   = r_rec_read;
        n_rec_skip   = r_rec_skip;
        status       = abeh_pkg::ST_DONE;
        op           = abeh_pkg::OP_NONE;
        idx_mate     = r_mate2;
        idx_base     = bidx[1:0];
        idx_qual     = i_quality - 8'd2;
        idx_cyc      = r_read_cycle;
        case (abeh_pkg::t_kind'(i_kind))
            abeh_pkg::KIND_START: begin
                n_read_cycle = '0;
                n_ref_offset = '0;
                n_match_rem  = '0;
                if ((i_flags & abeh_pkg::SKIP_FLAGS) != 12'd0 || i_contig_negative) begin
                    n_skipped  = 1'b1;
                    n_rec_skip = (&r_rec_skip) ? r_rec_skip : r_rec_skip + 32'd1;
                    status     = abeh_pkg::ST_IGNORED;
                end else begin
                    n_skipped  = 1'b0;
                    n_mate2    = ((i_flags & abeh_pkg::FIRST_MATE_FLAG) == 12'd0);
                    n_rec_read = (&r_rec_read) ? r_rec_read : r_rec_read + 32'd1;
                end
            end
            abeh_pkg::KIND_CIGAR: begin
                if (r_skipped) begin
                    status = abeh_pkg::ST_IGNORED;
                end else begin
                    n_read_cycle = (cyc_sum[29:28] != 2'b00) ? '1 : cyc_sum[27:0];
                    n_ref_offset = (ref_sum[33:32] != 2'b00) ? '1 : ref_sum[31:0];
                    n_match_rem  = '0;
                    case (abeh_pkg::t_cigar'(i_cigar_code))
                        abeh_pkg::CIG_M: n_match_rem = i_op_length;
                        abeh_pkg::CIG_I, abeh_pkg::CIG_D, abeh_pkg::CIG_N,
                        abeh_pkg::CIG_S, abeh_pkg::CIG_H, abeh_pkg::CIG_EQ,
                        abeh_pkg::CIG_X: ;
                        default: status = abeh_pkg::ST_IGNORED;
                    endcase
                end
            end
            abeh_pkg::KIND_BASE: begin
                if (r_skipped) begin
                    status = abeh_pkg::ST_IGNORED;
                end else if (r_match_rem == '0) begin
                    status = abeh_pkg::ST_NO_MATCH;
                end else begin
                    n_match_rem  = r_match_rem - 28'd1;
                    n_read_cycle = (&r_read_cycle) ? r_read_cycle : r_read_cycle + 28'd1;
                    n_ref_offset = (&r_ref_offset) ? r_ref_offset : r_ref_offset + 32'd1;
                    if (i_read_base == abeh_pkg::NT_N || i_ref_char == abeh_pkg::CHAR_N) begin
                        status = abeh_pkg::ST_IGNORED;
                    end else if (i_quality < 8'd2
                                 || {1'b0, i_quality} > 9'(NUM_QUALITIES + 1)) begin
                        status = abeh_pkg::ST_BAD_QUAL;
                    end else if (bidx[2]) begin
                        status = abeh_pkg::ST_BAD_BASE;
                    end else if ({4'd0, r_read_cycle} >= 32'(MAX_CYCLES)) begin
                        status = abeh_pkg::ST_BAD_CYC;
                    end else begin
                        op = abeh_pkg::OP_UPDATE;
                    end
                end
            end
            default: begin
                idx_mate = i_sel_mate;
                idx_base = i_sel_base;
                idx_qual = {2'b00, i_sel_quality};
                idx_cyc  = {20'd0, i_sel_cycle};
                if ({26'd0, i_sel_quality} >= 32'(NUM_QUALITIES)) begin
                    status = abeh_pkg::ST_BAD_QUAL;
                end else if ({24'd0, i_sel_cycle} >= 32'(MAX_CYCLES)) begin
                    status = abeh_pkg::ST_BAD_CYC;
                end else begin
                    op = abeh_pkg::OP_READ;
                end
            end
        endcase
    end

    assign idx_full = ((({31'd0, idx_mate} * 32'd4 + {30'd0, idx_base}) * 32'(NUM_QUALITIES)
                       + {24'd0, idx_qual}) * 32'(MAX_CYCLES)) + {4'd0, idx_cyc};

    always_comb begin
        o_job.status          = status;
        o_job.op              = op;
        o_job.mism            = (abeh_pkg::nt_code(i_ref_char) != i_read_base);
        o_job.addr            = idx_full[abeh_pkg::JOB_ADDR_W-1:0];
        o_job.read_cycle      = n_read_cycle;
        o_job.ref_offset      = n_ref_offset;
        o_job.records_read    = n_rec_read;
        o_job.records_skipped = n_rec_skip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_cycle <= '0;
            r_ref_offset <= '0;
            r_match_rem  <= '0;
            r_mate2      <= 1'b0;
            r_skipped    <= 1'b1;
            r_rec_read   <= '0;
            r_rec_skip   <= '0;
        end else if (i_accept) begin
            r_read_cycle <= n_read_cycle;
            r_ref_offset <= n_ref_offset;
            r_match_rem  <= n_match_rem;
            r_mate2      <= n_mate2;
            r_skipped    <= n_skipped;
            r_rec_read   <= n_rec_read;
            r_rec_skip   <= n_rec_skip;
        end
    end
endmodule

// File: rtl/core/abeh_back.sv
// ----------------------------------------------------------------------------
// abeh_back
// Holds the histogram store, clears it after reset, carries out read-modify-
// write and read-out jobs, and drives the result register.
// ----------------------------------------------------------------------------
module abeh_back #(
    parameter int NUM_QUALITIES = abeh_pkg::NUM_QUALITIES_DEF,
    parameter int MAX_CYCLES    = abeh_pkg::MAX_CYCLES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  abeh_pkg::t_job   i_job,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_clearing,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [2:0]       o_tuser,
    output logic [191:0]     o_tdata
);
    localparam int DEPTH = 8 * NUM_QUALITIES * MAX_CYCLES;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_FIN
    } t_state;

    logic [31:0]    obs_mem [DEPTH];
    logic [31:0]    err_mem [DEPTH];

    t_state         r_state;
    abeh_pkg::t_job r_job;
    logic           r_clearing;
    logic [AW-1:0]  r_clr_addr;
    logic [31:0]    r_obs_rd;
    logic [31:0]    r_err_rd;
    logic           r_valid;
    logic [2:0]     r_user;
    logic [191:0]   r_data;

    logic           slot_free;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [31:0]    obs_new;
    logic [31:0]    err_new;
    logic [31:0]    obs_out;
    logic [31:0]    err_out;

    assign slot_free = !r_valid || i_tready;
    assign o_pop     = (r_state == S_IDLE) && !r_clearing && !i_empty;

    assign obs_new = (&r_obs_rd) ? r_obs_rd : r_obs_rd + 32'd1;
    assign err_new = (r_job.mism && !(&r_err_rd)) ? r_err_rd + 32'd1 : r_err_rd;

    always_comb begin
        obs_out = '0;
        err_out = '0;
        case (r_job.op)
            abeh_pkg::OP_UPDATE: begin
                obs_out = obs_new;
                err_out = err_new;
            end
            abeh_pkg::OP_READ: begin
                obs_out = r_obs_rd;
                err_out = r_err_rd;
            end
            default: ;
        endcase
    end

    assign wr_en   = r_clearing
                     || (r_state == S_FIN && slot_free && r_job.op == abeh_pkg::OP_UPDATE);
    assign wr_addr = r_clearing ? r_clr_addr : r_job.addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            obs_mem[wr_addr] <= r_clearing ? 32'd0 : obs_new;
            err_mem[wr_addr] <= r_clearing ? 32'd0 : err_new;
        end
        r_obs_rd <= obs_mem[r_job.addr[AW-1:0]];
        r_err_rd <= err_mem[r_job.addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (r_clearing) begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            // In the final state the result register is reloaded below instead.
            if (r_valid && i_tready && r_state != S_FIN) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_job   <= i_job;
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_FIN;
                S_FIN: begin
                    if (slot_free) begin
                        r_valid <= 1'b1;
                        r_user  <= r_job.status;
                        r_data  <= {4'd0, r_job.records_skipped, r_job.records_read,
                                    r_job.ref_offset, r_job.read_cycle, err_out, obs_out};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_clearing = r_clearing;
    assign o_tvalid   = r_valid;
    assign o_tuser    = r_user;
    assign o_tdata    = r_data;
endmodule

// File: rtl/core/aligned_base_error_histogram.sv
// ----------------------------------------------------------------------------
// aligned_base_error_histogram
// Per mate, base, quality and read cycle counts of aligned bases and mismatches.
// ----------------------------------------------------------------------------
// After reset the block sweeps its store to zero, one entry per cycle, and no
// item is accepted until that pass is over. The front part takes one item per
// cycle into a two-entry queue while the queue is not full, updating record
// positions and counters at once. The back part works on one item at a time
// (store read, read data registered, write back and result load) and takes no
// new item until that result is loaded, so a stalled result register holds it.
// Each item gives exactly one result item.
module aligned_base_error_histogram #(
    parameter int NUM_QUALITIES = abeh_pkg::NUM_QUALITIES_DEF,
    parameter int MAX_CYCLES    = abeh_pkg::MAX_CYCLES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // flags, contig_negative, cigar_code, op_length, read_base, ref_char,
    // quality, sel_mate, sel_base, sel_quality, sel_cycle, zero pad
    input  logic [87:0]  s_axis_tdata,
    // kind
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // obs_count, err_count, read_cycle_now, ref_offset_now, records_read_out,
    // records_skipped_out, zero pad
    output logic [191:0] m_axis_tdata,
    // status
    output logic [2:0]   m_axis_tuser
);
    abeh_pkg::t_job front_job;
    abeh_pkg::t_job queue_job;
    logic           accept;
    logic           q_empty;
    logic           q_full;
    logic           pop;
    logic           clearing;

    assign s_axis_tready = !q_full && !clearing;
    assign accept        = s_axis_tvalid && s_axis_tready;

    abeh_front #(
        .NUM_QUALITIES (NUM_QUALITIES),
        .MAX_CYCLES    (MAX_CYCLES)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_kind            (s_axis_tuser),
        .i_flags           (s_axis_tdata[11:0]),
        .i_contig_negative (s_axis_tdata[12]),
        .i_cigar_code      (s_axis_tdata[16:13]),
        .i_op_length       (s_axis_tdata[44:17]),
        .i_read_base       (s_axis_tdata[48:45]),
        .i_ref_char        (s_axis_tdata[56:49]),
        .i_quality         (s_axis_tdata[64:57]),
        .i_sel_mate        (s_axis_tdata[65]),
        .i_sel_base        (s_axis_tdata[67:66]),
        .i_sel_quality     (s_axis_tdata[73:68]),
        .i_sel_cycle       (s_axis_tdata[81:74]),
        .o_job             (front_job)
    );

    abeh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    abeh_back #(
        .NUM_QUALITIES (NUM_QUALITIES),
        .MAX_CYCLES    (MAX_CYCLES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (queue_job),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tuser    (m_axis_tuser),
        .o_tdata    (m_axis_tdata)
    );
endmodule

// File: tb/aligned_base_error_histogram_test.sv
// ----------------------------------------------------------------------------
// aligned_base_error_histogram_test
// Drives whole alignment records, stray items and histogram read-outs into the
// block with random gaps on both sides. A model of the counts in the bench
// predicts every result item, and each one is checked field by field.
// ----------------------------------------------------------------------------
module aligned_base_error_histogram_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NQ         = abeh_pkg::NUM_QUALITIES_DEF;
    localparam int NC         = abeh_pkg::MAX_CYCLES_DEF;
    localparam int DEPTH      = 8 * NQ * NC;
    localparam int IDLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 750;

    typedef struct {
        abeh_pkg::t_kind kind;
        logic [11:0] flags;
        logic        contig_neg;
        logic [3:0]  cigar;
        logic [27:0] len;
        logic [3:0]  rbase;
        logic [7:0]  rchar;
        logic [7:0]  qual;
        logic        smate;
        logic [1:0]  sbase;
        logic [5:0]  squal;
        logic [7:0]  scyc;
    } t_item;

    typedef struct {
        abeh_pkg::t_status status;
        logic [31:0] obs;
        logic [31:0] err;
        logic [27:0] cyc;
        logic [31:0] off;
        logic [31:0] n_read;
        logic [31:0] n_skip;
    } t_count_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [87:0]  s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [191:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    aligned_base_error_histogram uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Bench copy of the block state.
    logic [31:0] obs_counts [DEPTH];
    logic [31:0] err_counts [DEPTH];
    logic [27:0] cycle_pos;
    logic [31:0] ref_pos;
    logic [27:0] match_left;
    logic        second_mate;
    logic        in_skipped;
    logic [31:0] n_records;
    logic [31:0] n_skipped;

    t_count_result expected_counts [$];
    int            touched_addrs [$];
    int            mismatches;
    int            items_sent;
    int            results_seen;
    int            idle_cycles;
    bit            gaps_on;
    int            rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [27:0] sat28(input logic [27:0] a, input logic [27:0] b);
        logic [28:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[28] ? 28'hFFF_FFFF : s[27:0];
    endfunction

    // IUPAC code of a reference character, case folded.
    function automatic logic [3:0] iupac_of(input logic [7:0] ch);
        logic [7:0] c;
        c = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
        case (c)
            "=": return 4'd0;
            "A": return 4'd1;
            "C": return 4'd2;
            "M": return 4'd3;
            "G": return 4'd4;
            "R": return 4'd5;
            "S": return 4'd6;
            "V": return 4'd7;
            "T", "U": return 4'd8;
            "W": return 4'd9;
            "Y": return 4'd10;
            "H": return 4'd11;
            "K": return 4'd12;
            "D": return 4'd13;
            "B": return 4'd14;
            default: return 4'd15;
        endcase
    endfunction

    function automatic int entry_addr(input int mate, input int b, input int q, input int c);
        return ((mate * 4 + b) * NQ + q) * NC + c;
    endfunction

    function automatic t_count_result count_item(input t_item it);
        t_count_result r;
        int            b;
        int            a;
        logic [27:0]   cyc;
        r = '{abeh_pkg::ST_DONE, 32'd0, 32'd0, 28'd0, 32'd0, 32'd0, 32'd0};
        case (it.kind)
            abeh_pkg::KIND_START: begin
                cycle_pos = '0;
                ref_pos = '0;
                match_left = '0;
                if ((it.flags & abeh_pkg::SKIP_FLAGS) != 12'd0 || it.contig_neg) begin
                    in_skipped = 1'b1;
                    n_skipped = sat32(n_skipped, 32'd1);
                    r.status = abeh_pkg::ST_IGNORED;
                end else begin
                    in_skipped = 1'b0;
                    second_mate = (it.flags & abeh_pkg::FIRST_MATE_FLAG) == 12'd0;
                    n_records = sat32(n_records, 32'd1);
                end
            end
            abeh_pkg::KIND_CIGAR: begin
                if (in_skipped) begin
                    r.status = abeh_pkg::ST_IGNORED;
                end else begin
                    // A cigar op closes any match still pending.
                    cycle_pos = sat28(cycle_pos, match_left);
                    ref_pos = sat32(ref_pos, {4'd0, match_left});
                    match_left = '0;
                    case (it.cigar)
                        abeh_pkg::CIG_M: match_left = it.len;
                        abeh_pkg::CIG_EQ, abeh_pkg::CIG_X: begin
                            cycle_pos = sat28(cycle_pos, it.len);
                            ref_pos = sat32(ref_pos, {4'd0, it.len});
                        end
                        abeh_pkg::CIG_I, abeh_pkg::CIG_S, abeh_pkg::CIG_H:
                            cycle_pos = sat28(cycle_pos, it.len);
                        abeh_pkg::CIG_D, abeh_pkg::CIG_N:
                            ref_pos = sat32(ref_pos, {4'd0, it.len});
                        default: r.status = abeh_pkg::ST_IGNORED;
                    endcase
                end
            end
            abeh_pkg::KIND_BASE: begin
                if (in_skipped) begin
                    r.status = abeh_pkg::ST_IGNORED;
                end else if (match_left == '0) begin
                    r.status = abeh_pkg::ST_NO_MATCH;
                end else begin
                    cyc = cycle_pos;
                    match_left = match_left - 28'd1;
                    cycle_pos = sat28(cycle_pos, 28'd1);
                    ref_pos = sat32(ref_pos, 32'd1);
                    case (it.rbase)
                        4'd1: b = 0;
                        4'd2: b = 1;
                        4'd4: b = 2;
                        4'd8: b = 3;
                        default: b = -1;
                    endcase
                    if (it.rbase == abeh_pkg::NT_N || it.rchar == abeh_pkg::CHAR_N) begin
                        r.status = abeh_pkg::ST_IGNORED;
                    end else if (it.qual < 2 || it.qual > NQ + 1) begin
                        r.status = abeh_pkg::ST_BAD_QUAL;
                    end else if (b < 0) begin
                        r.status = abeh_pkg::ST_BAD_BASE;
                    end else if (cyc >= NC) begin
                        r.status = abeh_pkg::ST_BAD_CYC;
                    end else begin
                        a = entry_addr(int'(second_mate), b, int'(it.qual) - 2, int'(cyc));
                        obs_counts[a] = sat32(obs_counts[a], 32'd1);
                        if (iupac_of(it.rchar) != it.rbase)
                            err_counts[a] = sat32(err_counts[a], 32'd1);
                        r.obs = obs_counts[a];
                        r.err = err_counts[a];
                        touched_addrs.push_back(a);
                    end
                end
            end
            default: begin
                if (it.squal >= NQ) begin
                    r.status = abeh_pkg::ST_BAD_QUAL;
                end else if (it.scyc >= NC) begin
                    r.status = abeh_pkg::ST_BAD_CYC;
                end else begin
                    a = entry_addr(int'(it.smate), int'(it.sbase), int'(it.squal),
                                   int'(it.scyc));
                    r.obs = obs_counts[a];
                    r.err = err_counts[a];
                end
            end
        endcase
        r.cyc = cycle_pos;
        r.off = ref_pos;
        r.n_read = n_records;
        r.n_skip = n_skipped;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch on result %0d: %s got %0h, expected %0h",
                 results_seen, what, got, want);
    endtask

    // Sends one item after a random gap and records its expected result.
    task automatic send_item(input t_item it);
        int gap;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = it.kind;
        s_axis_tdata = {6'd0, it.scyc, it.squal, it.sbase, it.smate, it.qual, it.rchar,
                        it.rbase, it.len, it.cigar, it.contig_neg, it.flags};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_counts.push_back(count_item(it));
        items_sent++;
    endtask

    function automatic t_item blank_item(input abeh_pkg::t_kind k);
        t_item it;
        it = '{k, 12'd0, 1'b0, 4'd0, 28'd0, 4'd0, 8'd0, 8'd0, 1'b0, 2'd0, 6'd0, 8'd0};
        return it;
    endfunction

    task automatic send_start(input logic [11:0] flags, input logic contig_neg);
        t_item it;
        it = blank_item(abeh_pkg::KIND_START);
        it.flags = flags;
        it.contig_neg = contig_neg;
        send_item(it);
    endtask

    task automatic send_cigar(input logic [3:0] code, input logic [27:0] len);
        t_item it;
        it = blank_item(abeh_pkg::KIND_CIGAR);
        it.cigar = code;
        it.len = len;
        send_item(it);
    endtask

    task automatic send_base(input logic [3:0] rbase, input logic [7:0] rchar,
                             input logic [7:0] qual);
        t_item it;
        it = blank_item(abeh_pkg::KIND_BASE);
        it.rbase = rbase;
        it.rchar = rchar;
        it.qual = qual;
        send_item(it);
    endtask

    task automatic send_readout(input logic smate, input logic [1:0] sbase,
                                input logic [5:0] squal, input logic [7:0] scyc);
        t_item it;
        it = blank_item(abeh_pkg::KIND_READ);
        it.smate = smate;
        it.sbase = sbase;
        it.squal = squal;
        it.scyc = scyc;
        send_item(it);
    endtask

    // The last item is taken away first so that it is not accepted again.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (expected_counts.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_record_handling();
        send_readout(1'b0, 2'd0, 6'd63, 8'd0);
        send_readout(1'b1, 2'd3, 6'd0, 8'd255);
        send_base(4'd1, "A", 8'd30);
        send_start(12'h040, 1'b0);
        send_base(4'd1, "A", 8'd30);
        send_cigar(4'd15, 28'd5);
        send_cigar(abeh_pkg::CIG_M, 28'd6);
        send_base(abeh_pkg::NT_N, "A", 8'd20);
        send_base(4'd2, "n", 8'd20);
        send_base(4'd4, "G", 8'd1);
        send_base(4'd4, "G", 8'd42);
        send_base(4'd3, "M", 8'd10);
        send_base(4'd8, "U", 8'd2);
        send_cigar(abeh_pkg::CIG_I, 28'd2);
        send_cigar(abeh_pkg::CIG_D, 28'd3);
        send_cigar(abeh_pkg::CIG_N, 28'd4);
        send_cigar(abeh_pkg::CIG_S, 28'd1);
        send_cigar(abeh_pkg::CIG_H, 28'd1);
        send_cigar(abeh_pkg::CIG_EQ, 28'd2);
        send_cigar(abeh_pkg::CIG_X, 28'd2);
        send_cigar(abeh_pkg::CIG_S, 28'd300);
        send_cigar(abeh_pkg::CIG_M, 28'd2);
        send_base(4'd1, "c", 8'd41);
        send_start(12'h100, 1'b0);
        send_cigar(abeh_pkg::CIG_M, 28'd1);
        send_base(4'd1, "A", 8'd20);
        send_start(12'h080, 1'b1);
    endtask

    task automatic test_position_saturation();
        send_start(12'h080, 1'b0);
        repeat (2) send_cigar(abeh_pkg::CIG_I, 28'hFFF_FFFF);
        repeat (17) send_cigar(abeh_pkg::CIG_D, 28'hFFF_FFFF);
        send_cigar(abeh_pkg::CIG_M, 28'hFFF_FFFF);
        send_base(4'd2, "C", 8'd20);
        send_cigar(abeh_pkg::CIG_H, 28'd1);
    endtask

    function automatic logic [7:0] pick_ref_char();
        string chars;
        chars = "ACGTACGTACGTacgtNn=URYKMSWBDHVX*";
        return chars[$urandom_range(0, chars.len() - 1)];
    endfunction

    task automatic send_random_record();
        int          n_ops;
        int          n_bases;
        logic [11:0] flags;
        logic [3:0]  code;
        logic [3:0]  rb;
        logic [7:0]  q;
        flags = 12'($urandom_range(0, 4095));
        if ($urandom_range(0, 9) != 0) flags &= ~abeh_pkg::SKIP_FLAGS;
        send_start(flags, $urandom_range(0, 19) == 0);
        n_ops = $urandom_range(1, 6);
        repeat (n_ops) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: code = abeh_pkg::CIG_M;
                4: code = abeh_pkg::CIG_I;
                5: code = abeh_pkg::CIG_D;
                6: code = abeh_pkg::CIG_S;
                7: code = $urandom_range(0, 1) ? abeh_pkg::CIG_EQ : abeh_pkg::CIG_X;
                8: code = $urandom_range(0, 1) ? abeh_pkg::CIG_N : abeh_pkg::CIG_H;
                default: code = 4'($urandom_range(0, 15));
            endcase
            n_bases = $urandom_range(1, 8);
            send_cigar(code, $urandom_range(0, 49) == 0 ? 28'd260 : 28'(n_bases));
            if (code == abeh_pkg::CIG_M) begin
                // Usually the whole op, sometimes cut short or overrun.
                case ($urandom_range(0, 7))
                    0: n_bases = $urandom_range(0, n_bases);
                    1: n_bases = n_bases + 1;
                    default: ;
                endcase
                repeat (n_bases) begin
                    case ($urandom_range(0, 11))
                        0: rb = 4'($urandom_range(0, 15));
                        1: rb = abeh_pkg::NT_N;
                        default: rb = 4'd1 << $urandom_range(0, 3);
                    endcase
                    q = $urandom_range(0, 11) == 0 ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(2, NQ + 1));
                    send_base(rb, pick_ref_char(), q);
                end
            end
        end
    endtask

    task automatic send_random_readout();
        int a;
        if (touched_addrs.size() != 0 && $urandom_range(0, 3) != 0) begin
            a = touched_addrs[$urandom_range(0, touched_addrs.size() - 1)];
            send_readout(1'(a / (4 * NQ * NC)), 2'((a / (NQ * NC)) % 4),
                         6'((a / NC) % NQ), 8'(a % NC));
        end else begin
            send_readout(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                         6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_noise_item();
        t_item it;
        it.kind = abeh_pkg::t_kind'($urandom_range(0, 3));
        it.flags = 12'($urandom_range(0, 4095));
        it.contig_neg = 1'($urandom_range(0, 1));
        it.cigar = 4'($urandom_range(0, 15));
        it.len = 28'($urandom_range(0, 28'hFFF_FFFF));
        it.rbase = 4'($urandom_range(0, 15));
        it.rchar = 8'($urandom_range(0, 255));
        it.qual = 8'($urandom_range(0, 255));
        it.smate = 1'($urandom_range(0, 1));
        it.sbase = 2'($urandom_range(0, 3));
        it.squal = 6'($urandom_range(0, 63));
        it.scyc = 8'($urandom_range(0, 255));
        send_item(it);
    endtask

    task automatic test_random_stream();
        int start_count;
        bit paused;
        start_count = items_sent;
        paused = 1'b0;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            // Alternate stretches with and without gaps on both sides.
            gaps_on = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 9))
                0: send_noise_item();
                1, 2: repeat ($urandom_range(1, 4)) send_random_readout();
                default: send_random_record();
            endcase
            if (!paused && items_sent - start_count > RANDOM_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        gaps_on = 1'b1;
        repeat (60) send_random_readout();
    endtask

    // Result side: random stalls, applied at the falling edge.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready = 1'b0;
            rx_hold--;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_count_result want;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("no progress for %0d cycles", IDLE_LIMIT);
            $display("aligned_base_error_histogram_test NOT OK");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rx_hold = gaps_on ? $urandom_range(0, 7) : 0;
            if (expected_counts.size() == 0) begin
                report_mismatch("unexpected result item", 32'(m_axis_tuser), 32'd0);
            end else begin
                want = expected_counts.pop_front();
                if (m_axis_tuser != want.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                if (m_axis_tdata[31:0] != want.obs)
                    report_mismatch("obs_count", m_axis_tdata[31:0], want.obs);
                if (m_axis_tdata[63:32] != want.err)
                    report_mismatch("err_count", m_axis_tdata[63:32], want.err);
                if (m_axis_tdata[91:64] != want.cyc)
                    report_mismatch("read_cycle_now", 32'(m_axis_tdata[91:64]),
                                    32'(want.cyc));
                if (m_axis_tdata[123:92] != want.off)
                    report_mismatch("ref_offset_now", m_axis_tdata[123:92], want.off);
                if (m_axis_tdata[155:124] != want.n_read)
                    report_mismatch("records_read_out", m_axis_tdata[155:124], want.n_read);
                if (m_axis_tdata[187:156] != want.n_skip)
                    report_mismatch("records_skipped_out", m_axis_tdata[187:156],
                                    want.n_skip);
            end
            results_seen++;
        end
    end

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            obs_counts[i] = '0;
            err_counts[i] = '0;
        end
        cycle_pos = '0;
        ref_pos = '0;
        match_left = '0;
        second_mate = 1'b0;
        in_skipped = 1'b1;
        n_records = '0;
        n_skipped = '0;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        rx_hold = 0;
        gaps_on = 1'b1;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_record_handling();
        test_position_saturation();
        test_random_stream();

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("sent %0d items (records, cigar ops, bases, read-outs, noise)",
                 items_sent);
        $display("checked %0d result items, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && expected_counts.size() == 0) begin
            $display("aligned_base_error_histogram_test OK");
        end else begin
            $display("aligned_base_error_histogram_test NOT OK");
        end
        $finish;
    end

endmodule
